// ===== src/wsig_pkg.sv =====
`default_nettype none
package wsig_pkg;

  // fixed field widths
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = 4;
  localparam int LEN_W     = 5;
  localparam int CNT_W     = 9;
  localparam int EXP_W     = 8;
  localparam int SEEN_W    = 32;
  localparam int ADDR_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [PAT_BYTES-1:0][7:0] pat_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MATCH   = 2'd1,
    ST_COUNT_DIFF = 2'd2,
    ST_INVALID    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_HIGH = 3'd1,
    REG_WILDCARD = 3'd2,
    REG_LENGTH   = 3'd3,
    REG_EXPECTED = 3'd4,
    REG_BASE     = 3'd5
  } cfg_idx_t;

  // configuration as seen by the cells and the tally
  typedef struct packed {
    pat_t                  pat;
    logic [PAT_BYTES-1:0]  wild;
    logic [LEN_W-1:0]      len;
    logic [EXP_W-1:0]      expected;
    logic [ADDR_W-1:0]     base;
  } cfg_t;

  // end-of-image summary from the tally
  typedef struct packed {
    logic              short_img;
    logic [CNT_W-1:0]  count;
    logic [SEEN_W-1:0] offset;
  } verdict_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage
`default_nettype wire

// ===== src/wsig_in_if.sv =====
`default_nettype none
interface wsig_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== src/wsig_out_if.sv =====
`default_nettype none
interface wsig_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] match_address;
  logic [8:0]  match_count;

  modport source (output valid, output status, output match_address, output match_count,
                  input ready);
  modport sink (input valid, input status, input match_address, input match_count,
                output ready);
endinterface
`default_nettype wire

// ===== src/wsig_cfg_if.sv =====
`default_nettype none
interface wsig_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/wsig_cell.sv =====
`default_nettype none
module wsig_cell #(
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           flush,
  input  wire logic [7:0]     byte_in,
  input  wire wsig_pkg::cfg_t cfg,
  output logic [7:0]          byte_out,
  output logic                hit
);
  import wsig_pkg::*;

  logic [7:0]           held;
  logic                 in_use;
  logic [LEN_W-1:0]     diff;
  logic [PAT_IDX_W-1:0] sel;

  // window slot IDX lines up with pattern byte len-1-IDX
  always_comb begin
    in_use = 6'(IDX) < {1'b0, cfg.len};
    diff   = cfg.len - LEN_W'(IDX + 1);
    sel    = diff[PAT_IDX_W-1:0];
    hit    = !in_use || cfg.wild[sel] || (byte_in == cfg.pat[sel]);
  end

  // shift the byte on, clear after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (adv) begin
      held <= flush ? 8'd0 : byte_in;
    end
  end

  assign byte_out = held;

endmodule
`default_nettype wire

// ===== src/wsig_tally.sv =====
`default_nettype none
module wsig_tally (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           acc,
  input  wire logic           last,
  input  wire logic           hit,
  input  wire wsig_pkg::cfg_t cfg,
  output logic                done_valid,
  output wsig_pkg::verdict_t  done
);
  import wsig_pkg::*;

  logic [SEEN_W-1:0] bytes_seen;
  logic [CNT_W-1:0]  matches_found;
  logic [SEEN_W-1:0] first_offset;

  logic              seen_sat;
  logic [SEEN_W-1:0] seen_next;
  logic              long_enough;
  logic              room;
  logic              check;
  logic [CNT_W-1:0]  matches_next;
  logic [SEEN_W-1:0] offset_next;

  // position count, match count and first offset for this beat
  always_comb begin
    seen_sat     = &bytes_seen;
    seen_next    = seen_sat ? bytes_seen : bytes_seen + 1'b1;
    long_enough  = seen_next >= SEEN_W'(cfg.len);
    room         = matches_found <= {1'b0, cfg.expected};
    check        = !seen_sat && long_enough && room && hit;
    matches_next = matches_found + CNT_W'(check);
    offset_next  = (check && matches_found == '0) ? seen_next - SEEN_W'(cfg.len)
                                                  : first_offset;
  end

  // running state, cleared after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      matches_found <= '0;
      first_offset  <= '0;
      done_valid    <= 1'b0;
    end else begin
      done_valid <= acc && last;
      if (acc) begin
        if (last) begin
          bytes_seen    <= '0;
          matches_found <= '0;
          first_offset  <= '0;
        end else begin
          bytes_seen    <= seen_next;
          matches_found <= matches_next;
          first_offset  <= offset_next;
        end
      end
    end
  end

  // summary of the image
  always_ff @(posedge clk) begin
    if (acc && last) begin
      done.short_img <= !long_enough;
      done.count     <= matches_next;
      done.offset    <= offset_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    !rst && acc && last |=> done_valid && bytes_seen == '0 && matches_found == '0)
    else $error("state not cleared after last beat");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !rst && !acc |=> $stable(bytes_seen) && $stable(matches_found) && $stable(first_offset))
    else $error("tally moved without a beat");

  a_first_kept: assert property (@(posedge clk) disable iff (rst)
    !rst && acc && !last && matches_found != '0 |=> $stable(first_offset))
    else $error("first offset overwritten");

endmodule
`default_nettype wire

// ===== src/wildcard_signature_search.sv =====
`default_nettype none
// Wildcard byte-pattern search. Takes one image byte per cycle while the input is not
// stalled and compares the newest pattern-length bytes against the configured pattern
// (wildcard bytes match anything) at every position; on the beat marked last it gives
// one verdict (ok with base plus first match offset, no match, count differs, or
// invalid range) and clears its state. The row of window cells shifts once per accepted
// beat, so input runs at one byte per cycle when not stalled; the verdict is registered
// in the tally and then waits in a two-entry output buffer. Input stalls only while two
// verdicts are held (buffered or about to enter the buffer) and none leaves in that
// cycle. Configuration writes are taken in any cycle and should be made between images.
module wildcard_signature_search #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  wsig_in_if.sink     din,
  wsig_out_if.source  dout,
  wsig_cfg_if.sink    cfg
);
  import wsig_pkg::*;

  localparam int CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

  cfg_t              cfg_q;
  logic [LEN_W-1:0]  len_wr;
  logic              acc;
  logic [7:0]        win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;
  logic              done_valid;
  verdict_t          done;
  result_t           res;
  result_t           q [2];
  logic [1:0]        q_count;
  logic              pop;
  logic              wr_idx;

  assign acc       = din.valid && din.ready;
  assign cfg.ready = 1'b1;

  // pattern length clamped to one .. cap
  always_comb begin
    len_wr = cfg.data[LEN_W-1:0];
    if (len_wr == '0) len_wr = LEN_W'(1);
    if (len_wr > LEN_W'(CAP)) len_wr = LEN_W'(CAP);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.pat      <= '0;
      cfg_q.wild     <= '0;
      cfg_q.len      <= LEN_W'(1);
      cfg_q.expected <= EXP_W'(1);
      cfg_q.base     <= '0;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        REG_PAT_LOW:  cfg_q.pat[7:0]  <= cfg.data;
        REG_PAT_HIGH: cfg_q.pat[15:8] <= cfg.data;
        REG_WILDCARD: cfg_q.wild      <= cfg.data[PAT_BYTES-1:0];
        REG_LENGTH:   cfg_q.len       <= len_wr;
        REG_EXPECTED: cfg_q.expected  <= cfg.data[EXP_W-1:0];
        REG_BASE:     cfg_q.base      <= cfg.data;
        default: ;
      endcase
    end
  end

  // window row, newest byte in cell zero
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wsig_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (acc),
      .flush    (din.last),
      .byte_in  ((k == 0) ? din.data_byte : win[(k == 0) ? 0 : k - 1]),
      .cfg      (cfg_q),
      .byte_out (win[k]),
      .hit      (hits[k])
    );
  end

  wsig_tally u_tally (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .last       (din.last),
    .hit        (&hits),
    .cfg        (cfg_q),
    .done_valid (done_valid),
    .done       (done)
  );

  // verdict from the summary
  always_comb begin
    res.addr  = '0;
    res.count = '0;
    if (done.short_img || cfg_q.base == '0) begin
      res.status = ST_INVALID;
    end else if (done.count == '0) begin
      res.status = ST_NO_MATCH;
    end else if (done.count != {1'b0, cfg_q.expected}) begin
      res.status = ST_COUNT_DIFF;
      res.count  = done.count;
    end else begin
      res.status = ST_OK;
      res.count  = done.count;
      res.addr   = cfg_q.base + {{(ADDR_W-SEEN_W){1'b0}}, done.offset};
    end
  end

  // two-entry output buffer, head drives the port
  assign pop       = dout.valid && dout.ready;
  assign wr_idx    = (q_count - {1'b0, pop}) != 2'd0;
  assign din.ready = (q_count + {1'b0, done_valid} - {1'b0, pop}) < 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count + {1'b0, done_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && !wr_idx) begin
      q[0] <= res;
    end else if (pop) begin
      q[0] <= q[1];
    end
    if (done_valid && wr_idx) begin
      q[1] <= res;
    end
  end

  assign dout.valid         = q_count != 2'd0;
  assign dout.status        = q[0].status;
  assign dout.match_address = q[0].addr;
  assign dout.match_count   = q[0].count;

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3)
    else $error("output buffer overflow");

  a_room_for_verdict: assert property (@(posedge clk) disable iff (rst)
    done_valid |-> q_count != 2'd2)
    else $error("verdict with no buffer room");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    done_valid && q_count != 2'd0 && !pop |-> !din.ready)
    else $error("input open while buffer may overflow");

endmodule
`default_nettype wire

// ===== test/wildcard_signature_search_test.sv =====
`timescale 1ns / 1ps
module wildcard_signature_search_test;
  import wsig_pkg::*;

  localparam int MAX_PAT = 16;
  localparam int ITEM_TARGET = 1950;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 6;
  localparam int SHOWN_ERRORS = 10;
  // unmapped register index, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // expected verdicts for the scanned images, built from a copy of the registers
  class verdict_scoreboard;
    logic [127:0] pattern;
    logic [15:0] wild;
    logic [4:0] len_reg;
    logic [7:0] expected;
    logic [63:0] base;
    logic [7:0] window [MAX_PAT];
    logic [31:0] seen;
    logic [8:0] found;
    logic [31:0] first_off;
    result_t verdicts_due[$];
    int errors;
    int images;
    int bytes;
    int writes;
    int by_status[4];

    function new();
      pattern = '0;
      wild = '0;
      len_reg = 5'd1;
      expected = 8'd1;
      base = '0;
      errors = 0;
      images = 0;
      bytes = 0;
      writes = 0;
      foreach (by_status[s]) by_status[s] = 0;
      clear_image();
    endfunction

    function void clear_image();
      foreach (window[k]) window[k] = 8'h00;
      seen = '0;
      found = '0;
      first_off = '0;
    endfunction

    // pattern length in force: zero means one, capped at the window size
    function int unsigned span();
      int unsigned cap;
      int unsigned n;
      cap = (MAX_PAT < 16) ? MAX_PAT : 16;
      n = (len_reg == 0) ? 1 : len_reg;
      return (n > cap) ? cap : n;
    endfunction

    // window[0] is the newest byte, so pattern byte i sits at window[n-1-i]
    function bit window_hits(int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (!wild[i] && window[n-1-i] != pattern[8*i +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
      writes++;
      case (idx)
        REG_PAT_LOW:  pattern[63:0] = v;
        REG_PAT_HIGH: pattern[127:64] = v;
        REG_WILDCARD: wild = v[15:0];
        REG_LENGTH:   len_reg = v[4:0];
        REG_EXPECTED: expected = v[7:0];
        REG_BASE:     base = v;
        default: ;
      endcase
    endfunction

    function void note_image_byte(logic [7:0] b, logic l);
      int unsigned n;
      result_t r;
      n = span();
      for (int k = MAX_PAT - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      bytes++;
      // position counter saturates; later bytes are no longer checked
      if (seen != 32'hFFFF_FFFF) begin
        seen++;
        if (seen >= n && found <= {1'b0, expected} && window_hits(n)) begin
          found++;
          if (found == 9'd1) first_off = seen - n;
        end
      end
      if (l) begin
        r.status = ST_INVALID;
        r.addr = '0;
        r.count = '0;
        if (base == 0 || seen < n) r.status = ST_INVALID;
        else if (found == 0) r.status = ST_NO_MATCH;
        else if (found != {1'b0, expected}) begin
          r.status = ST_COUNT_DIFF;
          r.count = found;
        end else begin
          r.status = ST_OK;
          r.addr = base + {32'h0, first_off};
          r.count = found;
        end
        verdicts_due = {verdicts_due, r};
        images++;
        by_status[r.status]++;
        clear_image();
      end
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= SHOWN_ERRORS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_verdict(logic [1:0] status, logic [63:0] addr, logic [8:0] count);
      result_t want;
      if (verdicts_due.size() == 0) begin
        complain($sformatf("verdict with none due: status %0d addr %h count %0d",
                           status, addr, count));
        return;
      end
      want = verdicts_due.pop_front();
      if (status !== want.status || addr !== want.addr || count !== want.count)
        complain($sformatf("verdict: expected status %0d addr %h count %0d, got %0d %h %0d",
                           want.status, want.addr, want.count, status, addr, count));
    endfunction
  endclass

  logic clk;
  logic rst;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int quiet_cycles = 0;
  verdict_scoreboard sb = new();

  wsig_in_if din();
  wsig_out_if dout();
  wsig_cfg_if cfg();

  wildcard_signature_search #(.MAX_PATTERN(MAX_PAT)) u_dut (
    .clk(clk),
    .rst(rst),
    .din(din),
    .dout(dout),
    .cfg(cfg)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side back-pressure
  always @(posedge clk) begin
    dout.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watch all three channels; verdicts are checked before new bytes are noted
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (dout.valid && dout.ready)
        sb.check_verdict(dout.status, dout.match_address, dout.match_count);
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (din.valid && din.ready) sb.note_image_byte(din.data_byte, din.last);
      if ((dout.valid && dout.ready) || (cfg.valid && cfg.ready) || (din.valid && din.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one image byte, with a random gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic l);
    if ($urandom_range(99) < send_gap_pct) begin
      din.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    din.valid <= 1'b1;
    din.data_byte <= b;
    din.last <= l;
    do @(posedge clk); while (!din.ready);
    sent++;
  endtask

  task automatic send_image(input logic [7:0] img[$]);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  // hold the input until every verdict is out and the pipeline is empty
  task automatic drain();
    din.valid <= 1'b0;
    @(posedge clk);
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // drop the write strobe and wait so the scoreboard has seen the last write
  task automatic finish_writes();
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_noise(ref logic [7:0] img[$], input int count);
    repeat (count) img = {img, 8'($urandom)};
  endfunction

  // one copy of the current pattern, wildcard bytes random
  function automatic void add_copy(ref logic [7:0] img[$]);
    int unsigned n;
    n = sb.span();
    for (int unsigned i = 0; i < n; i++)
      img = {img, (sb.wild[i] ? 8'($urandom) : sb.pattern[8*i +: 8])};
  endfunction

  // register values, biased toward short patterns, small counts and the extremes
  function automatic logic [63:0] reg_value(input logic [CFG_IDX_W-1:0] idx);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    case (idx)
      REG_WILDCARD: begin
        case ($urandom_range(4))
          0: junk[15:0] = 16'h0000;
          1: junk[15:0] = 16'hFFFF;
          2: ;
          default: junk[15:0] = junk[15:0] & 16'($urandom) & 16'($urandom);
        endcase
      end
      REG_LENGTH: begin
        case ($urandom_range(8))
          0: junk[4:0] = 5'd0;
          1: junk[4:0] = 5'd16;
          2: junk[4:0] = 5'($urandom_range(31, 17));
          default: junk[4:0] = 5'($urandom_range(6, 1));
        endcase
      end
      REG_EXPECTED: begin
        case ($urandom_range(6))
          0: junk[7:0] = 8'd0;
          1: junk[7:0] = 8'd255;
          default: junk[7:0] = 8'($urandom_range(3, 1));
        endcase
      end
      REG_BASE: begin
        case ($urandom_range(8))
          0: junk = '0;
          1: junk = '1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return junk;
  endfunction

  task automatic shuffle_config();
    drain();
    for (int r = REG_PAT_LOW; r <= REG_BASE; r++)
      if ($urandom_range(2) != 0) put_reg(r[CFG_IDX_W-1:0], reg_value(r[CFG_IDX_W-1:0]));
    finish_writes();
  endtask

  // mostly images with planted copies around the expected count, some noise
  task automatic random_image();
    logic [7:0] img[$];
    int unsigned n;
    int copies;
    n = sb.span();
    case ($urandom_range(9))
      0: add_noise(img, $urandom_range(30, 1));
      1: add_noise(img, $urandom_range(n, 1));
      default: begin
        if (sb.expected > 4) copies = $urandom_range(4);
        else copies = int'(sb.expected) - 1 + int'($urandom_range(2));
        if (copies < 0) copies = 0;
        add_noise(img, $urandom_range(3));
        repeat (copies) begin
          add_copy(img);
          add_noise(img, $urandom_range(4));
        end
        if (img.size() == 0) add_noise(img, 1);
      end
    endcase
    send_image(img);
  endtask

  task automatic directed_checks();
    logic [7:0] img[$];
    // registers at reset: zero base, so invalid range
    img = '{8'h00};
    send_image(img);
    // three-byte pattern holding both byte extremes
    drain();
    put_reg(REG_PAT_LOW, 64'h0123_4567_89A5_FF00);
    put_reg(REG_PAT_HIGH, 64'hFEDC_BA98_7654_3210);
    put_reg(REG_WILDCARD, 64'h0);
    put_reg(REG_LENGTH, 64'd3);
    put_reg(REG_EXPECTED, 64'd1);
    put_reg(REG_BASE, 64'h1000);
    put_reg(REG_SPARE, '1);
    finish_writes();
    // single hit at offset one
    img = '{8'hAA};
    add_copy(img);
    send_image(img);
    // near miss on the first byte
    img = '{8'h01, 8'hFF, 8'hA5};
    send_image(img);
    // two hits against one expected
    img = {};
    add_copy(img);
    add_copy(img);
    send_image(img);
    // image shorter than the pattern
    img = '{8'h00, 8'hFF};
    send_image(img);
    // expected zero: a hit can only give count differs
    drain();
    put_reg(REG_EXPECTED, 64'd0);
    finish_writes();
    img = {};
    add_copy(img);
    send_image(img);
    // zero length acts as one, all wildcard, base all ones
    drain();
    put_reg(REG_LENGTH, 64'd0);
    put_reg(REG_WILDCARD, 64'hFFFF);
    put_reg(REG_EXPECTED, 64'd1);
    put_reg(REG_BASE, '1);
    finish_writes();
    img = '{8'hFF};
    send_image(img);
    // oversize length clamps to the full window
    drain();
    put_reg(REG_LENGTH, 64'd31);
    put_reg(REG_WILDCARD, 64'h8001);
    put_reg(REG_BASE, 64'd5);
    finish_writes();
    img = {};
    add_copy(img);
    send_image(img);
  endtask

  // count saturation at 256 with every byte matching
  task automatic saturate_count();
    logic [7:0] img[$];
    drain();
    put_reg(REG_LENGTH, 64'd1);
    put_reg(REG_WILDCARD, 64'hFFFF);
    put_reg(REG_EXPECTED, 64'd255);
    put_reg(REG_BASE, {$urandom, $urandom} | 64'h1);
    finish_writes();
    add_noise(img, $urandom_range(262, 258));
    send_image(img);
  endtask

  // timeout guard
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase_end;
    rst = 1'b1;
    din.valid = 1'b0;
    din.data_byte = 8'h00;
    din.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    dout.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed_checks();
    saturate_count();

    // pacing phases: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 36; stall_pct = 36; end
      endcase
      phase_end = sent + (ITEM_TARGET - sent) / (4 - ph);
      while (sent < phase_end) begin
        if ($urandom_range(4) == 0) shuffle_config();
        random_image();
      end
    end

    drain();
    $display("scanned %0d images (%0d bytes) with %0d register writes over four pacing phases",
             sb.images, sb.bytes, sb.writes);
    $display("verdicts: %0d ok, %0d no match, %0d count differs, %0d invalid range",
             sb.by_status[ST_OK], sb.by_status[ST_NO_MATCH], sb.by_status[ST_COUNT_DIFF],
             sb.by_status[ST_INVALID]);
    if (sb.verdicts_due.size() != 0)
      $display("%0d verdicts never arrived", sb.verdicts_due.size());
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== wildcard_signature_search.f =====
src/wsig_pkg.sv
src/wsig_in_if.sv
src/wsig_out_if.sv
src/wsig_cfg_if.sv
src/wsig_cell.sv
src/wsig_tally.sv
src/wildcard_signature_search.sv
test/wildcard_signature_search_test.sv
